FILE: hdl/utf8_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 code point decoder checker.
// Included by the checker module; no other dependencies.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ucd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ucd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned PEND_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
  } ucd_result_t;

endpackage

`default_nettype wire

FILE: hdl/ucd_in_stage.sv
// Input register of the decoder: holds one accepted text byte.
// Depends on ucd_pkg.
`default_nettype none

module ucd_in_stage
  import ucd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,
  input  wire logic              out_space,   // downstream can take a byte this cycle
  output logic                   take,        // held byte moves to decode
  output logic [BYTE_W-1:0]      byte_q
);

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r;

  assign take      = vld_r & out_space;
  assign in_tready = ~vld_r | out_space;
  assign byte_q    = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take)      vld_nxt = 1'b0;
    if (in_tvalid && in_tready) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucd_decode.sv
// Sequence decoder: accumulator, pending count and lead classification.
// Depends on ucd_pkg.
`default_nettype none

module ucd_decode
  import ucd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] byte_q,
  output logic                   res_vld,
  output ucd_result_t            res
);

  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PEND_W-1:0] pend_dec;
  logic [CP_W-1:0]   done_val;
  logic              emit, bad_lead;

  assign pend_dec = pend_r - PEND_W'(1);

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    emit     = 1'b0;
    bad_lead = 1'b0;
    done_val = '0;
    if (pend_r != '0) begin
      // continuation: unchecked, low six bits shift in
      acc_nxt  = {acc_r[CP_W-7:0], byte_q[5:0]};
      pend_nxt = pend_dec;
      if (pend_dec == '0) begin
        emit     = 1'b1;
        done_val = acc_nxt;
        acc_nxt  = '0;
      end
    end else begin
      unique casez (byte_q)
        8'b0???????: begin
          emit     = 1'b1;
          done_val = CP_W'(byte_q);
          acc_nxt  = '0;
        end
        8'b111111??: begin
          acc_nxt  = CP_W'(byte_q & 8'h01);
          pend_nxt = 3'd5;
        end
        8'b111110??: begin
          acc_nxt  = CP_W'(byte_q & 8'h03);
          pend_nxt = 3'd4;
        end
        8'b11110???: begin
          acc_nxt  = CP_W'(byte_q & 8'h07);
          pend_nxt = 3'd3;
        end
        8'b1110????: begin
          acc_nxt  = CP_W'(byte_q & 8'h0f);
          pend_nxt = 3'd2;
        end
        8'b110?????: begin
          acc_nxt  = CP_W'(byte_q & 8'h1f);
          pend_nxt = 3'd1;
        end
        default: begin
          // stray continuation byte as a lead
          bad_lead = 1'b1;
          acc_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_vld        = take & (emit | bad_lead);
    res.code_point = done_val;
    if (bad_lead)             res.status = ST_INVALID;
    else if (done_val == '0)  res.status = ST_END;
    else                      res.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucd_out_stage.sv
// Result register of the decoder, drives the output stream.
// Depends on ucd_pkg.
`default_nettype none

module ucd_out_stage
  import ucd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_vld,
  input  ucd_result_t      res,
  output logic             out_space,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser
);

  logic        vld_r, vld_nxt;
  ucd_result_t res_r;

  assign out_space  = ~vld_r | out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {{(32-CP_W){1'b0}}, res_r.code_point};
  assign out_tuser  = res_r.status;

  always_comb begin
    vld_nxt = vld_r;
    if (out_tready) vld_nxt = 1'b0;
    if (res_vld)    vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/utf8_codepoint_decoder.sv
// UTF-8 code point decoder, top level (legacy one to six byte sequences).
// Depends on ucd_pkg, ucd_in_stage, ucd_decode and ucd_out_stage.
//
// Usage:
//   in_*  : one raw text byte per item (in_tdata[7:0]).
//   out_* : one item per completed character or bad lead byte:
//           out_tdata[30:0] code point, out_tdata[31] zero,
//           out_tuser[1:0] status (ok, end of text, invalid lead).
//   Continuation bytes are not checked; a byte 80..BF seen as a lead
//   gives an invalid item with code point zero. A completed value of
//   zero is reported as end of text.
// Timing:
//   One byte per cycle sustained while out_tready stays high. A byte waits in
//   the input register until the output register has space; its result, if
//   any, is then written to the output register, and out_tvalid rises once it is held there.
//   Bytes that only extend a sequence produce no output item.
// Reset (rst_n low, synchronous): both registers empty, decoder idle with
//   a cleared accumulator; in_tready is high on the first cycle after.
// Stall: while out_tready is low the result holds; the input register can
//   still take one more byte, after which in_tready drops until the
//   result is taken.
`default_nettype none

module utf8_codepoint_decoder
  import ucd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] text_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [30:0] code_point, [31] zero pad
  output logic [1:0]       out_tuser    // [1:0] status
);

  logic              out_space;
  logic              take;
  logic [BYTE_W-1:0] byte_q;
  logic              res_vld;
  ucd_result_t       res;

  // byte holding register, accepts a byte while empty even when the result stalls
  ucd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_space (out_space),
    .take      (take),
    .byte_q    (byte_q)
  );

  // accumulator and pending count advance only when a byte moves on
  ucd_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_q  (byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  ucd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .out_space  (out_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: hdl/ucd_checker.sv
// Port-level checker for the UTF-8 code point decoder, bound to the top.
// Depends on ucd_pkg and utf8_codepoint_decoder_assert.svh.
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module ucd_checker
  import ucd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  `UCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `UCD_ASSERT_NOW(a_ok_nonzero, out_tvalid && out_tuser == ST_OK, out_tdata != 32'd0, "ok item with zero code point")
  `UCD_ASSERT_NOW(a_end_bad_zero, out_tvalid && (out_tuser == ST_END || out_tuser == ST_INVALID), out_tdata == 32'd0, "end or invalid item with nonzero code point")
  `UCD_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

bind utf8_codepoint_decoder ucd_checker u_ucd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
